// ===== design/trd_pkg.sv =====
// Shared types and constants for the touch report decoder.
// No dependencies; every other design file imports this package.
package trd_pkg;

   localparam int REPORT_BYTES = 8;
   localparam int POS_W        = $clog2(REPORT_BYTES);
   localparam int HELD_BYTES   = REPORT_BYTES - 1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPORT_BYTES - 1);

   localparam int COORD_W  = 12;
   localparam int SECOND_W = 14;
   localparam logic [COORD_W-1:0] DELTA_HALF = 12'd2048;

   localparam logic [7:0] HEADER_CODE   = 8'h52;
   localparam logic [7:0] PROX_NEAR     = 8'h80;
   localparam logic [7:0] PROX_FAR      = 8'h40;
   localparam logic [7:0] ALL_ONES      = 8'hFF;
   localparam logic [7:0] KEY_NONE      = 8'h00;
   localparam logic [7:0] KEY_CODE_MENU = 8'h01;
   localparam logic [7:0] KEY_HOME      = 8'h02;

   localparam logic [1:0] KIND_INVALID = 2'd0;
   localparam logic [1:0] KIND_PROX    = 2'd1;
   localparam logic [1:0] KIND_TOUCH   = 2'd2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_XY    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MENU_KEY_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MENU_KEY_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_KEY_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_KEY_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_KEY_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_KEY_Y = 3'd6;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [2:0] {
      CLS_INVALID,
      CLS_NEAR,
      CLS_FAR,
      CLS_RELEASE,
      CLS_KEY,
      CLS_SINGLE,
      CLS_DUAL
   } report_class_type;

   typedef enum logic [1:0] {
      KEY_SEL_MENU,
      KEY_SEL_HOME,
      KEY_SEL_BACK
   } key_sel_type;

   typedef struct packed {
      report_class_type   cls;
      key_sel_type        key;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
   } entry_type;

   typedef struct packed {
      logic               swap_xy;
      logic [COORD_W-1:0] menu_key_x;
      logic [COORD_W-1:0] menu_key_y;
      logic [COORD_W-1:0] home_key_x;
      logic [COORD_W-1:0] home_key_y;
      logic [COORD_W-1:0] back_key_x;
      logic [COORD_W-1:0] back_key_y;
   } csr_type;

endpackage

// ===== design/trd_if.sv =====
// Valid/ready channel interfaces for report bytes and decoded results.
// Depends on trd_pkg for field widths.
interface trd_req_if;
   import trd_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] report_byte;
   logic       report_start;

   modport source (output valid, output report_byte, output report_start, input ready);
   modport sink (input valid, input report_byte, input report_start, output ready);
endinterface

interface trd_rsp_if;
   import trd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 report_kind;
   logic                       is_far;
   logic [1:0]                 point_count;
   logic [COORD_W-1:0]         first_x;
   logic [COORD_W-1:0]         first_y;
   logic signed [SECOND_W-1:0] second_x;
   logic signed [SECOND_W-1:0] second_y;

   modport source (output valid, output report_kind, output is_far, output point_count,
                   output first_x, output first_y, output second_x, output second_y,
                   input ready);
   modport sink (input valid, input report_kind, input is_far, input point_count,
                 input first_x, input first_y, input second_x, input second_y,
                 output ready);
endinterface

// ===== design/trd_front.sv =====
// Front end: collects report bytes, keeps the running sum and classifies
// each complete report. Depends on trd_pkg and trd_req_if.
module trd_front (
   input  logic               clock,
   input  logic               reset,
   trd_req_if.sink            req_ch,
   output logic               push_valid,
   input  logic               push_ready,
   output trd_pkg::entry_type push_data
);
   import trd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       held_ff [HELD_BYTES];
   logic [POS_W-1:0] pos_eff;
   logic [7:0]       sum_eff;
   logic             is_last;
   logic             accept;
   logic [7:0]       byte_val;
   logic             all_ones;
   entry_type        entry;

   assign byte_val = req_ch.report_byte;
   assign pos_eff  = req_ch.report_start ? '0 : pos_ff;
   assign sum_eff  = req_ch.report_start ? '0 : sum_ff;
   assign is_last  = (pos_eff == LAST_POS);

   // A byte that completes a report needs a free queue slot.
   assign req_ch.ready = (pos_ff != LAST_POS) || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (is_last) begin
            pos_in = '0;
            sum_in = '0;
         end else begin
            pos_in = pos_eff + POS_W'(1);
            sum_in = sum_eff + byte_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HELD_BYTES; i++) begin
         if (accept && !is_last && pos_eff == POS_W'(i)) begin
            held_ff[i] <= byte_val;
         end
      end
   end

   assign all_ones = (held_ff[1] == ALL_ONES) && (held_ff[2] == ALL_ONES) &&
                     (held_ff[3] == ALL_ONES) && (held_ff[4] == ALL_ONES) &&
                     (held_ff[6] == ALL_ONES);

   always_comb begin
      entry.px  = {held_ff[1][7:4], held_ff[2]};
      entry.py  = {held_ff[1][3:0], held_ff[3]};
      entry.dx  = {held_ff[4][7:4], held_ff[5]};
      entry.dy  = {held_ff[4][3:0], held_ff[6]};
      entry.key = KEY_SEL_BACK;
      if (held_ff[5] == KEY_CODE_MENU) begin
         entry.key = KEY_SEL_MENU;
      end else if (held_ff[5] == KEY_HOME) begin
         entry.key = KEY_SEL_HOME;
      end
      // Proximity codes in byte 5 win over header and checksum checks.
      priority if (held_ff[5] == PROX_NEAR) begin
         entry.cls = CLS_NEAR;
      end else if (held_ff[5] == PROX_FAR) begin
         entry.cls = CLS_FAR;
      end else if ((8'h00 - sum_ff) != byte_val || held_ff[0] != HEADER_CODE) begin
         entry.cls = CLS_INVALID;
      end else if (all_ones) begin
         if (held_ff[5] == KEY_NONE || held_ff[5] == ALL_ONES) begin
            entry.cls = CLS_RELEASE;
         end else begin
            entry.cls = CLS_KEY;
         end
      end else if (entry.dx == '0 && entry.dy == '0) begin
         entry.cls = CLS_SINGLE;
      end else begin
         entry.cls = CLS_DUAL;
      end
   end

   assign push_valid = req_ch.valid && is_last && push_ready;
   assign push_data  = entry;

endmodule

// ===== design/trd_queue.sv =====
// Short queue of classified reports between front and back ends.
// Depends on trd_pkg for the entry type.
module trd_queue #(
   parameter int DEPTH = trd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  trd_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output trd_pkg::entry_type pop_data
);
   import trd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/trd_back.sv =====
// Back end: turns a classified report into result fields and holds them in
// the output register. Depends on trd_pkg and trd_rsp_if.
module trd_back (
   input  logic               clock,
   input  logic               reset,
   input  trd_pkg::csr_type   csr,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  trd_pkg::entry_type pop_data,
   trd_rsp_if.source          rsp_ch
);
   import trd_pkg::*;

   logic                       valid_ff, valid_in;
   logic [1:0]                 kind_ff, kind_in;
   logic                       far_ff, far_in;
   logic [1:0]                 count_ff, count_in;
   logic [COORD_W-1:0]         fx_ff, fx_in;
   logic [COORD_W-1:0]         fy_ff, fy_in;
   logic signed [SECOND_W-1:0] sx_ff, sx_in;
   logic signed [SECOND_W-1:0] sy_ff, sy_in;
   logic signed [SECOND_W-1:0] dx_ext;
   logic signed [SECOND_W-1:0] dy_ext;
   logic signed [SECOND_W-1:0] sum_x;
   logic signed [SECOND_W-1:0] sum_y;
   logic                       load;

   assign pop_ready = !valid_ff || rsp_ch.ready;
   assign load      = pop_valid && pop_ready;

   // Raw deltas above half range stand for negative values (raw - 4096).
   assign dx_ext = (pop_data.dx > DELTA_HALF) ? {2'b11, pop_data.dx} : {2'b00, pop_data.dx};
   assign dy_ext = (pop_data.dy > DELTA_HALF) ? {2'b11, pop_data.dy} : {2'b00, pop_data.dy};
   assign sum_x  = dx_ext + $signed({2'b00, pop_data.px});
   assign sum_y  = dy_ext + $signed({2'b00, pop_data.py});

   always_comb begin
      kind_in  = KIND_TOUCH;
      far_in   = 1'b0;
      count_in = 2'd0;
      fx_in    = '0;
      fy_in    = '0;
      sx_in    = '0;
      sy_in    = '0;
      unique case (pop_data.cls)
         CLS_INVALID: kind_in = KIND_INVALID;
         CLS_NEAR: kind_in = KIND_PROX;
         CLS_FAR: begin
            kind_in = KIND_PROX;
            far_in  = 1'b1;
         end
         CLS_RELEASE: count_in = 2'd0;
         CLS_KEY: begin
            count_in = 2'd1;
            unique case (pop_data.key)
               KEY_SEL_MENU: begin
                  fx_in = csr.menu_key_x;
                  fy_in = csr.menu_key_y;
               end
               KEY_SEL_HOME: begin
                  fx_in = csr.home_key_x;
                  fy_in = csr.home_key_y;
               end
               default: begin
                  fx_in = csr.back_key_x;
                  fy_in = csr.back_key_y;
               end
            endcase
         end
         CLS_SINGLE: begin
            count_in = 2'd1;
            fx_in    = csr.swap_xy ? pop_data.py : pop_data.px;
            fy_in    = csr.swap_xy ? pop_data.px : pop_data.py;
         end
         CLS_DUAL: begin
            count_in = 2'd2;
            fx_in    = csr.swap_xy ? pop_data.py : pop_data.px;
            fy_in    = csr.swap_xy ? pop_data.px : pop_data.py;
            sx_in    = csr.swap_xy ? sum_y : sum_x;
            sy_in    = csr.swap_xy ? sum_x : sum_y;
         end
         default: kind_in = KIND_INVALID;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         far_ff   <= far_in;
         count_ff <= count_in;
         fx_ff    <= fx_in;
         fy_ff    <= fy_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.report_kind = kind_ff;
   assign rsp_ch.is_far      = far_ff;
   assign rsp_ch.point_count = count_ff;
   assign rsp_ch.first_x     = fx_ff;
   assign rsp_ch.first_y     = fy_ff;
   assign rsp_ch.second_x    = sx_ff;
   assign rsp_ch.second_y    = sy_ff;

endmodule

// ===== design/touch_report_decoder.sv =====
// Touch report decoder top level: register file, front end, queue, back end.
// Takes one report byte per cycle unless the queue is full at the eighth byte; that byte
// writes the decoded report into the queue, and the output register loads it from there.
// The queue holds up to QUEUE_DEPTH decoded reports while the result side stalls.
// Reset clears the byte count, running sum, queue, output valid and all
// configuration registers; held report bytes are not cleared.
module touch_report_decoder #(
   parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   trd_req_if.sink                            req_ch,
   trd_rsp_if.source                          rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [trd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import trd_pkg::*;

   csr_type   csr_ff, csr_in;
   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_data;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SWAP_XY:    csr_in.swap_xy    = csr_wr_data[0];
            CSR_MENU_KEY_X: csr_in.menu_key_x = csr_wr_data[COORD_W-1:0];
            CSR_MENU_KEY_Y: csr_in.menu_key_y = csr_wr_data[COORD_W-1:0];
            CSR_HOME_KEY_X: csr_in.home_key_x = csr_wr_data[COORD_W-1:0];
            CSR_HOME_KEY_Y: csr_in.home_key_y = csr_wr_data[COORD_W-1:0];
            CSR_BACK_KEY_X: csr_in.back_key_x = csr_wr_data[COORD_W-1:0];
            CSR_BACK_KEY_Y: csr_in.back_key_y = csr_wr_data[COORD_W-1:0];
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   trd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   trd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   trd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule
